[rtl/sbfr_pkg.sv]
`default_nettype none

package sbfr_pkg;

   // Timer and register widths.
   localparam int TIMER_WIDTH = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 2;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_TIMEOUT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIO_TIMEOUT = 2'd1;

   localparam logic [CSR_DATA_W-1:0] GAP_TIMEOUT_RESET   = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] RADIO_TIMEOUT_RESET = 16'd10000;

   // Frame layout.
   localparam int FRAME_LEN  = 25;
   localparam int POS_W      = 5;
   localparam int N_CHAN     = 16;
   localparam int CHAN_IDX_W = 4;
   localparam int CHAN_W     = 11;
   localparam int CHAN_BITS  = N_CHAN * CHAN_W;  // bytes 1..22 of the frame
   localparam int BYTE_W     = 8;

   localparam logic [POS_W-1:0] POS_HEADER = 5'd0;
   localparam logic [POS_W-1:0] POS_DATA_LAST = 5'd22;
   localparam logic [POS_W-1:0] POS_FLAGS  = 5'd23;
   localparam logic [POS_W-1:0] POS_FOOTER = 5'd24;

   localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h0F;
   localparam logic [BYTE_W-1:0] FOOTER_BYTE = 8'h00;
   localparam int FAILSAFE_BIT = 3;

   localparam logic [CHAN_IDX_W-1:0] CHAN_LAST = 4'd15;

   // Input word kinds carried on req_tuser.
   localparam logic FUNC_BYTE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // Result kinds carried on rsp_tuser.
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_CHANNEL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_BAD_FRAME  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RADIO_LOST = 2'd2;

   localparam int RSP_DATA_W = 24;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

[rtl/sbus_frame_receiver.sv]
// A bad frame or radio lost word is presented in the cycle after its input word is accepted;
// channel 0 of a good frame passes the sequencer, then the output register; the rest follow
// one per cycle while ready. Bytes and ticks are taken one per cycle while the output is free;
// a good frame's closing byte then stops input while channels leave the 176-bit shift register.
// Reset (synchronous, active high) clears the frame position, both timers, the radio lost flag,
// the output valid and the sequencer, and loads the timeouts with 1000 and 10000 microseconds.
`default_nettype none

module sbus_frame_receiver (
   input  wire logic        clock,
   input  wire logic        reset,

   // Input stream: one received byte or one microsecond tick per word.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  wire logic [0:0]  req_tuser,   // [0] func

   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                         // [15] failsafe, [16] radio_ok, rest zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast,

   // Configuration write channel.
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   // Configuration registers. Writes are always taken; an unknown index is dropped.
   logic [sbfr_pkg::CSR_DATA_W-1:0] gap_timeout_ff, gap_timeout_in;
   logic [sbfr_pkg::CSR_DATA_W-1:0] radio_timeout_ff, radio_timeout_in;

   // Frame tracking.
   logic [sbfr_pkg::POS_W-1:0]       pos_ff, pos_in;
   // Channel bits of bytes 1..22 enter at the top a byte at a time, so that after the last
   // data byte channel 0 sits in the lowest eleven bits; emitting shifts eleven bits down.
   logic [sbfr_pkg::CHAN_BITS-1:0]   chan_sr_ff, chan_sr_in;
   logic                             failsafe_ff, failsafe_in;
   logic [sbfr_pkg::CHAN_IDX_W-1:0]  chan_cnt_ff, chan_cnt_in;

   // Timers.
   logic [sbfr_pkg::TIMER_WIDTH-1:0] gap_timer_ff, gap_timer_in;
   logic [sbfr_pkg::TIMER_WIDTH-1:0] age_timer_ff, age_timer_in;
   logic [sbfr_pkg::TIMER_WIDTH-1:0] gap_inc, age_inc;
   logic                             radio_lost_ff, radio_lost_in;

   // Sequencer.
   sbfr_pkg::state_type state_ff, state_in;

   // Output register.
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [sbfr_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic [sbfr_pkg::KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic                             rsp_last_ff, rsp_last_in;

   // Control.
   logic slot_free;
   logic in_ready;
   logic emit_chan;
   logic req_acc;
   logic is_tick;
   logic byte_take;
   logic frame_end;
   logic frame_good;
   logic gap_expire;
   logic lost_fire;

   // The output slot can take a new word when it is empty or being drained this cycle.
   always_comb begin
      slot_free = !rsp_valid_ff || rsp_tready;
      in_ready  = 1'b0;
      emit_chan = 1'b0;
      unique case (state_ff)
         sbfr_pkg::ST_IDLE: begin
            in_ready = slot_free;
         end
         sbfr_pkg::ST_EMIT: begin
            emit_chan = slot_free;
         end
         default: begin
            in_ready  = 1'b0;
            emit_chan = 1'b0;
         end
      endcase
   end

   assign req_tready = in_ready;
   assign csr_ready  = 1'b1;

   assign req_acc    = req_tvalid && in_ready;
   assign is_tick    = (req_tuser[0] == sbfr_pkg::FUNC_TICK);
   // While hunting, only the header byte is taken into the frame.
   assign byte_take  = req_acc && !is_tick &&
                       ((pos_ff != sbfr_pkg::POS_HEADER) || (req_tdata == sbfr_pkg::HEADER_BYTE));
   assign frame_end  = byte_take && (pos_ff == sbfr_pkg::POS_FOOTER);
   assign frame_good = frame_end && (req_tdata == sbfr_pkg::FOOTER_BYTE);

   // Saturating timer increments.
   assign gap_inc = (gap_timer_ff == '1) ? gap_timer_ff : gap_timer_ff + 1'b1;
   assign age_inc = (age_timer_ff == '1) ? age_timer_ff : age_timer_ff + 1'b1;
   assign gap_expire = gap_inc > gap_timeout_ff;
   assign lost_fire  = req_acc && is_tick && (age_inc > radio_timeout_ff) && !radio_lost_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sbfr_pkg::ST_IDLE: begin
            if (frame_good) begin
               state_in = sbfr_pkg::ST_EMIT;
            end
         end
         sbfr_pkg::ST_EMIT: begin
            if (emit_chan && (chan_cnt_ff == sbfr_pkg::CHAN_LAST)) begin
               state_in = sbfr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sbfr_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      gap_timeout_in   = gap_timeout_ff;
      radio_timeout_in = radio_timeout_ff;
      pos_in           = pos_ff;
      chan_sr_in       = chan_sr_ff;
      failsafe_in      = failsafe_ff;
      chan_cnt_in      = chan_cnt_ff;
      gap_timer_in     = gap_timer_ff;
      age_timer_in     = age_timer_ff;
      radio_lost_in    = radio_lost_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_last_in      = rsp_last_ff;

      if (csr_valid) begin
         unique case (csr_index)
            sbfr_pkg::CSR_GAP_TIMEOUT:   gap_timeout_in   = csr_data;
            sbfr_pkg::CSR_RADIO_TIMEOUT: radio_timeout_in = csr_data;
            default: begin
            end
         endcase
      end

      if (req_acc && is_tick) begin
         if (gap_expire) begin
            pos_in       = sbfr_pkg::POS_HEADER;
            gap_timer_in = '0;
         end else begin
            gap_timer_in = gap_inc;
         end
         age_timer_in = age_inc;
         if (lost_fire) begin
            radio_lost_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = sbfr_pkg::KIND_RADIO_LOST;
            rsp_data_in   = '0;
            rsp_last_in   = 1'b1;
         end
      end

      if (req_acc && !is_tick) begin
         gap_timer_in = '0;
      end

      if (byte_take) begin
         pos_in = pos_ff + 1'b1;
         if ((pos_ff != sbfr_pkg::POS_HEADER) && (pos_ff <= sbfr_pkg::POS_DATA_LAST)) begin
            chan_sr_in = {req_tdata, chan_sr_ff[sbfr_pkg::CHAN_BITS-1:sbfr_pkg::BYTE_W]};
         end
         if (pos_ff == sbfr_pkg::POS_FLAGS) begin
            failsafe_in = req_tdata[sbfr_pkg::FAILSAFE_BIT];
         end
      end

      if (frame_end) begin
         pos_in        = sbfr_pkg::POS_HEADER;
         age_timer_in  = '0;
         radio_lost_in = 1'b0;
         chan_cnt_in   = '0;
         if (!frame_good) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = sbfr_pkg::KIND_BAD_FRAME;
            rsp_data_in  = '0;
            rsp_last_in  = 1'b1;
         end
      end

      // One channel per cycle while the output slot is free, from the bottom of the shift register.
      if (emit_chan) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = sbfr_pkg::KIND_CHANNEL;
         rsp_data_in  = {7'd0, !failsafe_ff, failsafe_ff,
                         chan_sr_ff[sbfr_pkg::CHAN_W-1:0], chan_cnt_ff};
         rsp_last_in  = (chan_cnt_ff == sbfr_pkg::CHAN_LAST);
         chan_sr_in   = {{sbfr_pkg::CHAN_W{1'b0}},
                         chan_sr_ff[sbfr_pkg::CHAN_BITS-1:sbfr_pkg::CHAN_W]};
         chan_cnt_in  = chan_cnt_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sbfr_pkg::ST_IDLE;
         gap_timeout_ff   <= sbfr_pkg::GAP_TIMEOUT_RESET;
         radio_timeout_ff <= sbfr_pkg::RADIO_TIMEOUT_RESET;
         pos_ff           <= sbfr_pkg::POS_HEADER;
         chan_cnt_ff      <= '0;
         gap_timer_ff     <= '0;
         age_timer_ff     <= '0;
         radio_lost_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         gap_timeout_ff   <= gap_timeout_in;
         radio_timeout_ff <= radio_timeout_in;
         pos_ff           <= pos_in;
         chan_cnt_ff      <= chan_cnt_in;
         gap_timer_ff     <= gap_timer_in;
         age_timer_ff     <= age_timer_in;
         radio_lost_ff    <= radio_lost_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chan_sr_ff  <= chan_sr_in;
      failsafe_ff <= failsafe_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The input stays closed while the channels of a frame are being sent.
   a_no_input_while_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sbfr_pkg::ST_EMIT) |-> !req_tready)
      else $error("input accepted during channel emission");

   // The frame position never reaches the frame length.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= sbfr_pkg::POS_FOOTER)
      else $error("frame position out of range");

   // Sending the sixteenth channel ends the burst.
   a_emit_ends: assert property (@(posedge clock) disable iff (reset)
      (emit_chan && (chan_cnt_ff == sbfr_pkg::CHAN_LAST)) |=>
         (state_ff == sbfr_pkg::ST_IDLE) && rsp_tlast)
      else $error("channel burst did not end after the last channel");

   // A radio lost report leaves the flag set so it is not repeated.
   a_lost_once: assert property (@(posedge clock) disable iff (reset)
      lost_fire |=> radio_lost_ff && (rsp_tuser == sbfr_pkg::KIND_RADIO_LOST))
      else $error("radio lost report without flag");

   // A good frame always starts its burst at channel zero.
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      frame_good |=> (state_ff == sbfr_pkg::ST_EMIT) && (chan_cnt_ff == '0))
      else $error("channel burst started at wrong channel");

endmodule

`default_nettype wire

[sim/sbus_frame_receiver_tb.sv]
module sbus_frame_receiver_tb;

   // A run with no accepted word on any channel for this many cycles is a hang.
   localparam int WATCHDOG_LIMIT = 2000;
   // Quiet cycles after the last expected result before a register write or the verdict.
   // They cover the output register and a tick that produces no result.
   localparam int DRAIN_CYCLES = 24;
   // Length of the long receiver hold-off that backs the block up into its input.
   localparam int HOLD_CYCLES = 400;
   // Random words queued in each idling phase.
   localparam int PHASE_WORDS = 75;
   // Two register indexes that the block does not implement; writes to them are dropped.
   localparam logic [sbfr_pkg::CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [sbfr_pkg::CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic       func;
      logic [7:0] data;
   } link_word_type;

   typedef struct packed {
      logic [sbfr_pkg::KIND_W-1:0]     kind;
      logic [sbfr_pkg::CHAN_IDX_W-1:0] index;
      logic [sbfr_pkg::CHAN_W-1:0]     value;
      logic                            failsafe;
      logic                            working;
      logic                            last;
   } decoded_type;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] rx_byte
   logic [0:0]  req_tuser = '0;   // [0] func

   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [23:0] rsp_tdata;        // [3:0] index, [14:4] value, [15] failsafe, [16] working
   wire  [1:0]  rsp_tuser;        // [1:0] kind
   wire         rsp_tlast;

   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   sbus_frame_receiver DUT (.*);

   always #5 clock = ~clock;

   // Words waiting to go out on the serial link side, filled by the sequence below.
   link_word_type link_words[$];
   int words_queued = 0;
   int words_taken = 0;

   // Idling knobs, in percent of cycles, and the hold-off requests for the receiver.
   int send_idle_pct = 0;
   int stall_pct = 0;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   // Shadow copy of the decoder: frame position and bytes, both timers, the lost flag,
   // and the two timeouts as the block should hold them.
   logic [7:0]  frame_bytes[sbfr_pkg::FRAME_LEN];
   int unsigned frame_pos;
   logic [15:0] gap_count;
   logic [15:0] age_count;
   logic [15:0] gap_limit;
   logic [15:0] radio_limit;
   bit          radio_lost;

   // Results the decoder owes us, oldest first.
   decoded_type decoded_due[$];
   int failures = 0;
   int quiet_cycles = 0;

   // Advance the shadow decoder by one accepted word and queue whatever it should emit.
   task automatic decode_word(input logic func, input logic [7:0] data);
      logic [sbfr_pkg::CHAN_BITS-1:0] payload;
      decoded_type r;
      logic fs;
      int i;
      int ch;
      r = '0;
      if (func == sbfr_pkg::FUNC_TICK) begin
         // Both timers saturate rather than wrap.
         if (gap_count != '1) gap_count++;
         if (gap_count > gap_limit) begin
            frame_pos = 0;
            gap_count = '0;
         end
         if (age_count != '1) age_count++;
         // Radio loss is reported once, then stays quiet until a frame completes.
         if (age_count > radio_limit && !radio_lost) begin
            radio_lost = 1'b1;
            r.kind = sbfr_pkg::KIND_RADIO_LOST;
            r.last = 1'b1;
            decoded_due.push_back(r);
         end
      end else begin
         gap_count = '0;
         // While hunting, only the header byte opens a frame.
         if (frame_pos != 0 || data == sbfr_pkg::HEADER_BYTE) begin
            frame_bytes[frame_pos] = data;
            frame_pos++;
         end
         if (frame_pos == sbfr_pkg::FRAME_LEN) begin
            frame_pos = 0;
            age_count = '0;
            radio_lost = 1'b0;
            if (frame_bytes[sbfr_pkg::POS_FOOTER] != sbfr_pkg::FOOTER_BYTE) begin
               r.kind = sbfr_pkg::KIND_BAD_FRAME;
               r.last = 1'b1;
               decoded_due.push_back(r);
            end else begin
               // Channels are packed little endian across bytes 1 to 22.
               for (i = 0; i < sbfr_pkg::CHAN_BITS / sbfr_pkg::BYTE_W; i++)
                  payload[8*i +: 8] = frame_bytes[i+1];
               fs = frame_bytes[sbfr_pkg::POS_FLAGS][sbfr_pkg::FAILSAFE_BIT];
               for (ch = 0; ch < sbfr_pkg::N_CHAN; ch++) begin
                  r.kind = sbfr_pkg::KIND_CHANNEL;
                  r.index = sbfr_pkg::CHAN_IDX_W'(ch);
                  r.value = payload[sbfr_pkg::CHAN_W*ch +: sbfr_pkg::CHAN_W];
                  r.failsafe = fs;
                  r.working = ~fs;
                  r.last = (ch == sbfr_pkg::N_CHAN - 1);
                  decoded_due.push_back(r);
               end
            end
         end
      end
   endtask

   // Compare one accepted result word with the oldest owed result.
   task automatic check_result();
      decoded_type want;
      logic [23:0] want_data;
      if (decoded_due.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result word: kind %0d tdata %h last %b",
                     rsp_tuser, rsp_tdata, rsp_tlast);
      end else begin
         want = decoded_due.pop_front();
         want_data = {7'b0, want.working, want.failsafe, want.value, want.index};
         if (rsp_tuser !== want.kind || rsp_tdata !== want_data || rsp_tlast !== want.last)
         begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch: expected kind %0d ch %0d value %0d fs %b working %b last %b",
                        want.kind, want.index, want.value, want.failsafe, want.working,
                        want.last);
               $display("  got kind %0d ch %0d value %0d fs %b working %b last %b (tdata %h)",
                        rsp_tuser, rsp_tdata[3:0], rsp_tdata[14:4],
                        rsp_tdata[15], rsp_tdata[16], rsp_tlast, rsp_tdata);
            end
         end
      end
   endtask

   // Monitor. Register writes and accepted input words update the shadow decoder before
   // the result word of the same edge is checked; the block answers a word in the following
   // cycle at the earliest, so the expectation is always in place first.
   always @(posedge clock) begin
      if (reset) begin
         frame_pos = 0;
         gap_count = '0;
         age_count = '0;
         radio_lost = 1'b0;
         gap_limit = sbfr_pkg::GAP_TIMEOUT_RESET;
         radio_limit = sbfr_pkg::RADIO_TIMEOUT_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sbfr_pkg::CSR_GAP_TIMEOUT: gap_limit = csr_data;
               sbfr_pkg::CSR_RADIO_TIMEOUT: radio_limit = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_word(req_tuser[0], req_tdata);
            words_taken++;
         end
         if (rsp_tvalid && rsp_tready) check_result();
      end
   end

   // Link-side driver: offers the next queued word, idling at random between words.
   always @(posedge clock) begin : feed_link
      link_word_type next_word;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (link_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = link_words.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= next_word.data;
            req_tuser <= next_word.func;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result-side receiver: random stalls, plus a long hold-off when one is asked for.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != holds_asked) begin
         rsp_tready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_served <= holds_served + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: counts cycles in which no channel accepts anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void push_word(input logic func, input logic [7:0] data);
      link_word_type w;
      w.func = func;
      w.data = data;
      link_words.push_back(w);
      words_queued++;
   endfunction

   function automatic void push_ticks(input int count);
      repeat (count) push_word(sbfr_pkg::FUNC_TICK, 8'($urandom));
   endfunction

   // Queue the first length bytes of a frame. Ticks may be slipped in between bytes.
   function automatic void push_frame(input fill_type fill, input logic [7:0] flags,
                                      input logic [7:0] footer, input int tick_pct,
                                      input int length);
      logic [7:0] b;
      int i;
      for (i = 0; i < length; i++) begin
         if (i == sbfr_pkg::POS_HEADER) b = sbfr_pkg::HEADER_BYTE;
         else if (i <= sbfr_pkg::POS_DATA_LAST) begin
            case (fill)
               FILL_ZERO: b = 8'h00;
               FILL_ONES: b = 8'hFF;
               default:   b = 8'($urandom);
            endcase
         end
         else if (i == sbfr_pkg::POS_FLAGS) b = flags;
         else b = footer;
         if (i != sbfr_pkg::POS_HEADER && $urandom_range(99) < tick_pct)
            push_word(sbfr_pkg::FUNC_TICK, 8'($urandom));
         push_word(sbfr_pkg::FUNC_BYTE, b);
      end
   endfunction

   task automatic write_reg(input logic [sbfr_pkg::CSR_INDEX_W-1:0] index,
                            input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued word is taken and every owed result has come back, then
   // give the block time to finish any tick that produced nothing.
   task automatic settle();
      while (words_taken != words_queued || decoded_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random traffic: mostly well-formed frames with random content, plus tick bursts,
   // stray bytes, frames with a bad footer and frames cut short.
   task automatic random_traffic(input int tick_pct);
      int phase_start;
      int pick;
      int fill_pick;
      fill_type fill;
      phase_start = words_queued;
      while (words_queued - phase_start < PHASE_WORDS) begin
         pick = $urandom_range(99);
         fill_pick = $urandom_range(99);
         fill = (fill_pick < 15) ? FILL_ZERO : (fill_pick < 30) ? FILL_ONES : FILL_RANDOM;
         if (pick < 55)
            push_frame(fill, 8'($urandom), sbfr_pkg::FOOTER_BYTE,
                       $urandom_range(1) ? 0 : tick_pct, sbfr_pkg::FRAME_LEN);
         else if (pick < 65)
            push_frame(fill, 8'($urandom), 8'($urandom_range(1, 255)), 0,
                       sbfr_pkg::FRAME_LEN);
         else if (pick < 80)
            push_ticks($urandom_range(1, 12));
         else if (pick < 90)
            repeat ($urandom_range(1, 4)) push_word(sbfr_pkg::FUNC_BYTE, 8'($urandom));
         else
            push_frame(fill, 8'($urandom), 8'($urandom), tick_pct, $urandom_range(1, 24));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part, with short timeouts so that the timer cases come quickly.
      write_reg(sbfr_pkg::CSR_GAP_TIMEOUT, 16'd3);
      write_reg(sbfr_pkg::CSR_RADIO_TIMEOUT, 16'd6);
      // Stray bytes while hunting are dropped.
      push_word(sbfr_pkg::FUNC_BYTE, 8'h00);
      push_word(sbfr_pkg::FUNC_BYTE, 8'hFF);
      // All channels at full scale with the failsafe flag raised.
      push_frame(FILL_ONES, 8'h08, sbfr_pkg::FOOTER_BYTE, 0, sbfr_pkg::FRAME_LEN);
      // A partial frame is thrown away once the byte gap runs out; the radio is then
      // reported lost once, and a further tick stays quiet.
      push_word(sbfr_pkg::FUNC_BYTE, sbfr_pkg::HEADER_BYTE);
      push_word(sbfr_pkg::FUNC_BYTE, 8'h55);
      push_ticks(9);
      // A frame with a nonzero footer gives a single bad frame result.
      push_frame(FILL_ZERO, 8'h00, 8'hFF, 0, sbfr_pkg::FRAME_LEN);
      settle();

      // Phase with no idling: both timeouts at their maximum, writes to the spare
      // indexes, and a long receiver hold-off while full frames keep arriving.
      send_idle_pct = 0;
      stall_pct = 0;
      write_reg(sbfr_pkg::CSR_GAP_TIMEOUT, 16'hFFFF);
      write_reg(sbfr_pkg::CSR_RADIO_TIMEOUT, 16'hFFFF);
      write_reg(CSR_SPARE_2, 16'($urandom));
      write_reg(CSR_SPARE_3, 16'($urandom));
      holds_asked++;
      push_frame(FILL_RANDOM, 8'($urandom), sbfr_pkg::FOOTER_BYTE, 0, sbfr_pkg::FRAME_LEN);
      push_frame(FILL_RANDOM, 8'($urandom), sbfr_pkg::FOOTER_BYTE, 0, sbfr_pkg::FRAME_LEN);
      random_traffic(8);
      settle();

      // Sender idle most of the time; zero timeouts expire on the first tick.
      send_idle_pct = 76;
      stall_pct = 0;
      write_reg(sbfr_pkg::CSR_GAP_TIMEOUT, 16'd0);
      write_reg(sbfr_pkg::CSR_RADIO_TIMEOUT, 16'd0);
      random_traffic(0);
      settle();

      // Receiver stalling most of the time; a gap timeout of one tick.
      send_idle_pct = 0;
      stall_pct = 76;
      write_reg(sbfr_pkg::CSR_GAP_TIMEOUT, 16'd1);
      write_reg(sbfr_pkg::CSR_RADIO_TIMEOUT, 16'($urandom_range(10, 40)));
      write_reg(CSR_SPARE_2, 16'($urandom));
      random_traffic(8);
      settle();

      // Both sides idle some of the time, moderate timeouts.
      send_idle_pct = 38;
      stall_pct = 38;
      write_reg(sbfr_pkg::CSR_GAP_TIMEOUT, 16'($urandom_range(2, 6)));
      write_reg(sbfr_pkg::CSR_RADIO_TIMEOUT, 16'($urandom_range(20, 60)));
      random_traffic(8);
      settle();

      if (failures == 0 && decoded_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[files.f]
rtl/sbfr_pkg.sv
rtl/sbus_frame_receiver.sv
sim/sbus_frame_receiver_tb.sv
